@@ sv/cascade_synapse_update_macros.svh @@
// assertion helpers for the checker file
`ifndef CASCADE_SYNAPSE_UPDATE_MACROS_SVH
`define CASCADE_SYNAPSE_UPDATE_MACROS_SVH

// same-cycle implication, off while reset is low
`define CSU_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("csu assertion failed");

// next-cycle implication, off while reset is low
`define CSU_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("csu assertion failed");

// next-cycle implication that also watches reset itself
`define CSU_ASSERT_ALWAYS_NXT(lbl, clk, a, b) \
    lbl: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("csu assertion failed");

`endif

@@ sv/csu_pkg.sv @@
package csu_pkg;

    localparam int NUM_SYNAPSES = 1024;
    localparam int NUM_LAYERS   = 3;

    localparam int IDX_W     = 10;
    localparam int LAYER_W   = 2;
    localparam int DRAW_W    = 16;
    localparam int THR_W     = 17;
    localparam int CNT_W     = 11;
    localparam int SIG_W     = 12;
    localparam int CFG_IDX_W = 3;

    // the index field reaches at most 2**IDX_W entries
    localparam int MEM_DEPTH = (NUM_SYNAPSES < (2 ** IDX_W)) ? NUM_SYNAPSES : (2 ** IDX_W);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LAYER_W-1:0] LAYER_MAX = LAYER_W'(NUM_LAYERS - 1);
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PLASTIC_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLASTIC_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLASTIC_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_META_0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_META_1    = 3'd4;

    localparam logic [THR_W-1:0] RST_PLASTIC_0 = 17'd65536;
    localparam logic [THR_W-1:0] RST_PLASTIC_1 = 17'd32768;
    localparam logic [THR_W-1:0] RST_PLASTIC_2 = 17'd16384;
    localparam logic [THR_W-1:0] RST_META_0    = 17'd65536;
    localparam logic [THR_W-1:0] RST_META_1    = 17'd32768;

    typedef enum logic [1:0] {
        MODE_INIT       = 2'd0,
        MODE_STORE      = 2'd1,
        MODE_BACKGROUND = 2'd2,
        MODE_SWEEP_END  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_INIT,
        OP_EVENT,
        OP_SWEEP_END
    } t_op;

    typedef enum logic {
        BK_READ,
        BK_EXEC
    } t_back_state;

    typedef struct packed {
        logic [THR_W-1:0] plastic_0;
        logic [THR_W-1:0] plastic_1;
        logic [THR_W-1:0] plastic_2;
        logic [THR_W-1:0] meta_0;
        logic [THR_W-1:0] meta_1;
    } t_thr;

    typedef struct packed {
        t_op                op;
        logic               in_range;
        logic [IDX_W-1:0]   idx;
        logic [LAYER_W-1:0] layer;
        logic               strength;
        logic               memory;
        logic               stored_dir;
        logic               potentiate;
        logic [DRAW_W-1:0]  draw;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

    typedef struct packed {
        logic               memory;
        logic [LAYER_W-1:0] layer;
        logic               strength;
    } t_entry;

endpackage

@@ sv/csu_cfg_regs.sv @@
module csu_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [csu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [csu_pkg::THR_W-1:0]      i_cfg_data,
    output csu_pkg::t_thr                  o_thr
);

    csu_pkg::t_thr r_thr;
    csu_pkg::t_thr n_thr;

    assign o_cfg_ready = 1'b1;
    assign o_thr       = r_thr;

    always_comb begin
        n_thr = r_thr;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                csu_pkg::CFG_PLASTIC_0: n_thr.plastic_0 = i_cfg_data;
                csu_pkg::CFG_PLASTIC_1: n_thr.plastic_1 = i_cfg_data;
                csu_pkg::CFG_PLASTIC_2: n_thr.plastic_2 = i_cfg_data;
                csu_pkg::CFG_META_0:    n_thr.meta_0    = i_cfg_data;
                csu_pkg::CFG_META_1:    n_thr.meta_1    = i_cfg_data;
                default:                n_thr           = r_thr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.plastic_0 <= csu_pkg::RST_PLASTIC_0;
            r_thr.plastic_1 <= csu_pkg::RST_PLASTIC_1;
            r_thr.plastic_2 <= csu_pkg::RST_PLASTIC_2;
            r_thr.meta_0    <= csu_pkg::RST_META_0;
            r_thr.meta_1    <= csu_pkg::RST_META_1;
        end else begin
            r_thr <= n_thr;
        end
    end

endmodule

@@ sv/csu_front.sv @@
module csu_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_mode,
    input  logic [csu_pkg::IDX_W-1:0]     i_synapse_index,
    input  logic [csu_pkg::LAYER_W-1:0]   i_init_layer,
    input  logic                          i_init_strength,
    input  logic                          i_init_memory,
    input  logic                          i_potentiate,
    input  logic [csu_pkg::DRAW_W-1:0]    i_draw,
    output csu_pkg::t_cmd_req             o_req,
    input  logic                          i_pop
);

    csu_pkg::t_cmd               r_q [csu_pkg::QUEUE_DEPTH];
    logic [csu_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [csu_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [csu_pkg::QCNT_W-1:0]  r_count;
    logic [csu_pkg::QPTR_W-1:0]  n_wr_ptr;
    logic [csu_pkg::QPTR_W-1:0]  n_rd_ptr;
    logic [csu_pkg::QCNT_W-1:0]  n_count;
    csu_pkg::t_cmd               cls_cmd;
    logic                        push;
    logic                        pop;

    // classify the incoming item
    always_comb begin
        cls_cmd            = '0;
        cls_cmd.in_range   = (32'(i_synapse_index) < csu_pkg::NUM_SYNAPSES);
        cls_cmd.idx        = i_synapse_index;
        cls_cmd.layer      = (i_init_layer > csu_pkg::LAYER_MAX) ? csu_pkg::LAYER_MAX
                                                                 : i_init_layer;
        cls_cmd.strength   = i_init_strength;
        cls_cmd.memory     = i_init_memory;
        cls_cmd.potentiate = i_potentiate;
        cls_cmd.draw       = i_draw;
        unique case (csu_pkg::t_mode'(i_mode))
            csu_pkg::MODE_INIT: begin
                cls_cmd.op = csu_pkg::OP_INIT;
            end
            csu_pkg::MODE_STORE: begin
                cls_cmd.op         = csu_pkg::OP_EVENT;
                cls_cmd.stored_dir = 1'b1;
            end
            csu_pkg::MODE_BACKGROUND: begin
                cls_cmd.op = csu_pkg::OP_EVENT;
            end
            csu_pkg::MODE_SWEEP_END: begin
                cls_cmd.op = csu_pkg::OP_SWEEP_END;
            end
        endcase
    end

    assign o_in_stall = (r_count == csu_pkg::QCNT_W'(csu_pkg::QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_count != '0);

    assign o_req.valid = (r_count != '0);
    assign o_req.cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == csu_pkg::QPTR_W'(csu_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == csu_pkg::QPTR_W'(csu_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_cmd;
        end
    end

endmodule

@@ sv/csu_back.sv @@
module csu_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  csu_pkg::t_cmd_req                 i_req,
    output logic                              o_pop,
    input  csu_pkg::t_thr                     i_thr,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_new_strength,
    output logic [csu_pkg::LAYER_W-1:0]       o_new_layer,
    output logic signed [csu_pkg::SIG_W-1:0]  o_excess_signal,
    output logic                              o_signal_valid
);

    csu_pkg::t_back_state            r_state;
    csu_pkg::t_back_state            n_state;
    csu_pkg::t_cmd                   r_cmd;
    csu_pkg::t_entry                 r_mem [csu_pkg::MEM_DEPTH];
    csu_pkg::t_entry                 r_rd_data;
    logic [csu_pkg::CNT_W-1:0]       r_sweep;
    logic [csu_pkg::CNT_W-1:0]       r_base;
    logic [csu_pkg::CNT_W-1:0]       n_sweep;
    logic [csu_pkg::CNT_W-1:0]       n_base;
    logic                            r_out_valid;
    logic                            r_out_str;
    logic [csu_pkg::LAYER_W-1:0]     r_out_layer;
    logic [csu_pkg::SIG_W-1:0]       r_out_excess;
    logic                            r_out_sig;

    logic                            rd_en;
    logic                            wr_en;
    logic                            load;
    logic                            out_take;
    logic                            cur_s;
    logic [csu_pkg::LAYER_W-1:0]     cur_l;
    logic                            mem_bit;
    logic                            dir;
    logic                            plastic_hit;
    logic                            meta_hit;
    logic                            upd_s;
    logic [csu_pkg::LAYER_W-1:0]     upd_l;
    logic                            upd_mem;
    logic [csu_pkg::SIG_W-1:0]       res_exc;
    logic                            res_sig;
    logic                            do_write;
    logic                            count_sweep;
    logic                            count_base;
    logic                            clear_sweep;

    function automatic logic [csu_pkg::THR_W-1:0] plastic_sel(
        csu_pkg::t_thr thr, logic [csu_pkg::LAYER_W-1:0] layer);
        if (layer == csu_pkg::LAYER_W'(0)) return thr.plastic_0;
        if (layer == csu_pkg::LAYER_W'(1)) return thr.plastic_1;
        return thr.plastic_2;
    endfunction

    function automatic logic [csu_pkg::THR_W-1:0] meta_sel(
        csu_pkg::t_thr thr, logic [csu_pkg::LAYER_W-1:0] layer);
        return (layer == csu_pkg::LAYER_W'(0)) ? thr.meta_0 : thr.meta_1;
    endfunction

    function automatic logic [csu_pkg::CNT_W-1:0] sat_inc(logic [csu_pkg::CNT_W-1:0] c);
        return (c == csu_pkg::CNT_MAX) ? c : c + 1'b1;
    endfunction

    assign out_take = r_out_valid && !i_out_stall;

    // synapse update on the read data
    always_comb begin
        cur_s       = r_cmd.in_range ? r_rd_data.strength : 1'b0;
        cur_l       = r_cmd.in_range ? r_rd_data.layer : '0;
        mem_bit     = r_rd_data.memory;
        dir         = r_cmd.stored_dir ? mem_bit : r_cmd.potentiate;
        plastic_hit = ({1'b0, r_cmd.draw} < plastic_sel(i_thr, cur_l));
        meta_hit    = ({1'b0, r_cmd.draw} < meta_sel(i_thr, cur_l));
        upd_s       = cur_s;
        upd_l       = cur_l;
        upd_mem     = mem_bit;
        res_exc     = '0;
        res_sig     = 1'b0;
        do_write    = 1'b0;
        count_sweep = 1'b0;
        count_base  = 1'b0;
        clear_sweep = 1'b0;
        unique case (r_cmd.op)
            csu_pkg::OP_INIT: begin
                if (r_cmd.in_range) begin
                    upd_s      = r_cmd.strength;
                    upd_l      = r_cmd.layer;
                    upd_mem    = r_cmd.memory;
                    do_write   = 1'b1;
                    count_base = (r_cmd.memory == r_cmd.strength);
                end
            end
            csu_pkg::OP_EVENT: begin
                if (r_cmd.in_range) begin
                    if (cur_s != dir) begin
                        if (plastic_hit) begin
                            upd_s = ~cur_s;
                            upd_l = '0;
                        end
                    end else if ((cur_l < csu_pkg::LAYER_MAX) && meta_hit) begin
                        upd_l = cur_l + 1'b1;
                    end
                    do_write    = 1'b1;
                    count_sweep = (mem_bit == upd_s);
                end
            end
            csu_pkg::OP_SWEEP_END: begin
                res_exc     = csu_pkg::SIG_W'({1'b0, r_sweep}) - csu_pkg::SIG_W'({1'b0, r_base});
                res_sig     = 1'b1;
                clear_sweep = 1'b1;
            end
            default: begin
                res_sig = 1'b0;
            end
        endcase
    end

    // read, then update and write back
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        load    = 1'b0;
        n_sweep = r_sweep;
        n_base  = r_base;
        unique case (r_state)
            csu_pkg::BK_READ: begin
                if (i_req.valid) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = csu_pkg::BK_EXEC;
                end
            end
            csu_pkg::BK_EXEC: begin
                if (!r_out_valid || out_take) begin
                    load    = 1'b1;
                    wr_en   = do_write;
                    n_state = csu_pkg::BK_READ;
                    if (clear_sweep) begin
                        n_sweep = '0;
                    end else if (count_sweep) begin
                        n_sweep = sat_inc(r_sweep);
                    end
                    if (count_base) begin
                        n_base = sat_inc(r_base);
                    end
                end
            end
            default: begin
                n_state = csu_pkg::BK_READ;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csu_pkg::BK_READ;
            r_sweep     <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_base  <= n_base;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_req.cmd;
        end
        if (load) begin
            r_out_str    <= upd_s;
            r_out_layer  <= upd_l;
            r_out_excess <= res_exc;
            r_out_sig    <= res_sig;
        end
    end

    // synapse store
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[i_req.cmd.idx[csu_pkg::ADDR_W-1:0]];
        end
        if (wr_en) begin
            r_mem[r_cmd.idx[csu_pkg::ADDR_W-1:0]] <= '{memory: upd_mem, layer: upd_l,
                                                       strength: upd_s};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_new_strength  = r_out_str;
    assign o_new_layer     = r_out_layer;
    assign o_excess_signal = $signed(r_out_excess);
    assign o_signal_valid  = r_out_sig;

endmodule

@@ sv/cascade_synapse_update.sv @@
// cascade synapse update: a store of binary synapses with cascade layers
// input channel: i_in_valid / o_in_stall, one synapse request per accept;
//   mode selects init, storage event, background event or end of sweep
// output channel: o_out_valid / i_out_stall, exactly one result per request
//   in request order: new strength and layer, and on end of sweep the
//   sweep match count minus the baseline with o_signal_valid set
// config channel: i_cfg_valid / o_cfg_ready (always ready), index 0..2 are
//   the plastic thresholds, 3..4 the metaplastic ones; other indexes ignored
// an accepted request passes the queue, the memory read and the output register;
// the back end takes no new request until it is through with the read-modify-write
//   of the last one on the synapse memory (registered read, then update and write back)
// a 2-entry request queue sits in front, so two requests are taken while
//   the back end is busy; when full o_in_stall rises
// a stalled result holds in the output register; the back end then waits
//   with its next request read and the queue keeps filling
// reset: thresholds return to defaults, counts clear, queue and output
//   empty; the synapse memory keeps its contents and must be loaded by
//   init requests before use
module cascade_synapse_update (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic [csu_pkg::IDX_W-1:0]         i_synapse_index,
    input  logic [csu_pkg::LAYER_W-1:0]       i_init_layer,
    input  logic                              i_init_strength,
    input  logic                              i_init_memory,
    input  logic                              i_potentiate,
    input  logic [csu_pkg::DRAW_W-1:0]        i_draw,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_new_strength,
    output logic [csu_pkg::LAYER_W-1:0]       o_new_layer,
    output logic signed [csu_pkg::SIG_W-1:0]  o_excess_signal,
    output logic                              o_signal_valid,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [csu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [csu_pkg::THR_W-1:0]         i_cfg_data
);

    csu_pkg::t_cmd_req req;
    csu_pkg::t_thr     thr;
    logic              pop;

    // threshold registers
    csu_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_thr       (thr)
    );

    // accept, classify and queue requests
    csu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_synapse_index (i_synapse_index),
        .i_init_layer    (i_init_layer),
        .i_init_strength (i_init_strength),
        .i_init_memory   (i_init_memory),
        .i_potentiate    (i_potentiate),
        .i_draw          (i_draw),
        .o_req           (req),
        .i_pop           (pop)
    );

    // synapse memory, update rules, match counters and result register
    csu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req),
        .o_pop           (pop),
        .i_thr           (thr),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_new_strength  (o_new_strength),
        .o_new_layer     (o_new_layer),
        .o_excess_signal (o_excess_signal),
        .o_signal_valid  (o_signal_valid)
    );

endmodule

@@ sv/csu_checker.sv @@
`include "cascade_synapse_update_macros.svh"

module csu_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_new_strength,
    input logic [csu_pkg::LAYER_W-1:0]       o_new_layer,
    input logic signed [csu_pkg::SIG_W-1:0]  o_excess_signal,
    input logic                              o_signal_valid
);

    logic                                          out_plain;
    logic                                          out_held;
    logic [csu_pkg::LAYER_W+csu_pkg::SIG_W+1:0]    out_bus;

    assign out_plain = o_out_valid && !o_signal_valid;
    assign out_held  = o_out_valid && i_out_stall;
    assign out_bus   = {o_new_strength, o_new_layer, o_excess_signal, o_signal_valid};

    // no result right after reset
    `CSU_ASSERT_ALWAYS_NXT(a_rst_empties_out, i_clk, !i_rst_n, !o_out_valid)

    // only end of sweep carries a nonzero excess
    `CSU_ASSERT_IMP(a_quiet_excess, i_clk, i_rst_n, out_plain, o_excess_signal == '0)

    // stalled result holds
    `CSU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_bus))

endmodule

bind cascade_synapse_update csu_checker u_csu_checker (.*);
